/* hw/rtl/rpcf_pkg.sv */
// package for the roll and pitch complementary filter
// holds the microcode table, the step codes and the divider request and response types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rpcf_pkg;

  // shared restoring divider: numerator, divisor and quotient widths
  localparam int unsigned DIV_NUM_W = 34;
  localparam int unsigned DIV_DEN_W = 25;
  localparam int unsigned DIV_Q_W   = 17;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

  // datapath operations, one per control word
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_DEN,
    OP_DIV_WEIGHT,
    OP_TAKE_WEIGHT,
    OP_RATE_MUL,
    OP_INC_ROUND,
    OP_INC_SCALE,
    OP_DIFF,
    OP_CORR_MUL,
    OP_CORR,
    OP_AXIS_NEXT,
    OP_MARK_OK,
    OP_FIRST,
    OP_RESTART,
    OP_HOLD,
    OP_EMIT
  } op_e;

  // jump conditions: jump to target when true, else step on
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_RESTART,
    C_NOT_VALID,
    C_DT_ZERO,
    C_DIV_BUSY,
    C_AXIS0,
    C_OUT_BLOCKED
  } cond_e;

  localparam int unsigned PC_W = 5;

  localparam logic [PC_W-1:0] PC_IDLE       = 5'd0;
  localparam logic [PC_W-1:0] PC_CHK_RST    = 5'd1;
  localparam logic [PC_W-1:0] PC_CHK_FIRST  = 5'd2;
  localparam logic [PC_W-1:0] PC_CHK_DT     = 5'd3;
  localparam logic [PC_W-1:0] PC_DEN        = 5'd4;
  localparam logic [PC_W-1:0] PC_W_START    = 5'd5;
  localparam logic [PC_W-1:0] PC_W_WAIT     = 5'd6;
  localparam logic [PC_W-1:0] PC_RATE_MUL   = 5'd7;
  localparam logic [PC_W-1:0] PC_INC_ROUND  = 5'd8;
  localparam logic [PC_W-1:0] PC_INC_SCALE  = 5'd9;
  localparam logic [PC_W-1:0] PC_DIFF       = 5'd10;
  localparam logic [PC_W-1:0] PC_CORR_MUL   = 5'd11;
  localparam logic [PC_W-1:0] PC_CORR       = 5'd12;
  localparam logic [PC_W-1:0] PC_NEXT_AXIS  = 5'd13;
  localparam logic [PC_W-1:0] PC_MARK_OK    = 5'd14;
  localparam logic [PC_W-1:0] PC_FIRST      = 5'd15;
  localparam logic [PC_W-1:0] PC_RESTART    = 5'd16;
  localparam logic [PC_W-1:0] PC_HOLD       = 5'd17;
  localparam logic [PC_W-1:0] PC_EMIT       = 5'd18;
  localparam logic [PC_W-1:0] PC_RET        = 5'd19;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ucode_word_t;

  function automatic ucode_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_word_t w;
    unique case (pc)
      PC_IDLE:      w = '{op: OP_LATCH,       cond: C_NO_INPUT,    target: PC_IDLE};
      PC_CHK_RST:   w = '{op: OP_NOP,         cond: C_RESTART,     target: PC_RESTART};
      PC_CHK_FIRST: w = '{op: OP_NOP,         cond: C_NOT_VALID,   target: PC_FIRST};
      PC_CHK_DT:    w = '{op: OP_NOP,         cond: C_DT_ZERO,     target: PC_HOLD};
      PC_DEN:       w = '{op: OP_DEN,         cond: C_NEXT,        target: PC_IDLE};
      PC_W_START:   w = '{op: OP_DIV_WEIGHT,  cond: C_NEXT,        target: PC_IDLE};
      PC_W_WAIT:    w = '{op: OP_TAKE_WEIGHT, cond: C_DIV_BUSY,    target: PC_W_WAIT};
      PC_RATE_MUL:  w = '{op: OP_RATE_MUL,    cond: C_NEXT,        target: PC_IDLE};
      PC_INC_ROUND: w = '{op: OP_INC_ROUND,   cond: C_NEXT,        target: PC_IDLE};
      PC_INC_SCALE: w = '{op: OP_INC_SCALE,   cond: C_NEXT,        target: PC_IDLE};
      PC_DIFF:      w = '{op: OP_DIFF,        cond: C_NEXT,        target: PC_IDLE};
      PC_CORR_MUL:  w = '{op: OP_CORR_MUL,    cond: C_NEXT,        target: PC_IDLE};
      PC_CORR:      w = '{op: OP_CORR,        cond: C_NEXT,        target: PC_IDLE};
      PC_NEXT_AXIS: w = '{op: OP_AXIS_NEXT,   cond: C_AXIS0,       target: PC_RATE_MUL};
      PC_MARK_OK:   w = '{op: OP_MARK_OK,     cond: C_ALWAYS,      target: PC_EMIT};
      PC_FIRST:     w = '{op: OP_FIRST,       cond: C_ALWAYS,      target: PC_EMIT};
      PC_RESTART:   w = '{op: OP_RESTART,     cond: C_ALWAYS,      target: PC_EMIT};
      PC_HOLD:      w = '{op: OP_HOLD,        cond: C_NEXT,        target: PC_IDLE};
      PC_EMIT:      w = '{op: OP_EMIT,        cond: C_OUT_BLOCKED, target: PC_EMIT};
      PC_RET:       w = '{op: OP_NOP,         cond: C_ALWAYS,      target: PC_IDLE};
      default:      w = '{op: OP_NOP,         cond: C_ALWAYS,      target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rpcf_div.sv */
// restoring unsigned divider, one quotient bit per cycle
// depends on rpcf_pkg for widths and the request and response structs
`timescale 1ns / 1ps
`default_nettype none

module rpcf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rpcf_pkg::div_req_t req_i,
  output rpcf_pkg::div_rsp_t rsp_o
);
  import rpcf_pkg::*;

  localparam int unsigned DSH_W = DIV_DEN_W + DIV_Q_W - 1;
  localparam int unsigned CNT_W = $clog2(DIV_Q_W);

  logic [DIV_NUM_W-1:0] rem_q;
  logic [DSH_W-1:0]     dsh_q;
  logic [DIV_Q_W-1:0]   quot_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q;

  logic [DSH_W-1:0] rem_ext;
  logic             ge;

  // quotient is known to fit DIV_Q_W bits, so the divisor starts pre-shifted
  assign rem_ext = DSH_W'(rem_q);
  assign ge      = rem_ext >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DIV_Q_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.num;
      dsh_q  <= DSH_W'(req_i.den) << (DIV_Q_W - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= DIV_NUM_W'(rem_ext - dsh_q);
      end
      quot_q <= {quot_q[DIV_Q_W-2:0], ge};
      dsh_q  <= dsh_q >> 1;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = quot_q;

endmodule

`default_nettype wire

/* hw/rtl/roll_pitch_complementary_filter.sv */
// roll and pitch complementary filter: microcoded sequencer over a small datapath
// restart, first sample and zero step each run their own step and go on to the result step;
// a full update first computes the weight on the divider, then runs both axes through the same steps
// one item at a time: the next transaction is taken only after the result is issued
// reset: estimates zero, no estimate held, time constant 1000 ms, output register empty
// depends on rpcf_pkg and rpcf_div
`timescale 1ns / 1ps
`default_nettype none

module roll_pitch_complementary_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] accel_roll_i,
  input  logic signed [15:0] accel_pitch_i,
  input  logic signed [15:0] gyro_roll_rate_i,
  input  logic signed [15:0] gyro_pitch_rate_i,
  input  logic        [15:0] step_time_us_i,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] roll_estimate_o,
  output logic signed [15:0] pitch_estimate_o,
  output logic               accepted_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [13:0] cfg_data_i
);
  import rpcf_pkg::*;

  localparam logic signed [17:0] HALF_TURN = 18'sd23040;
  localparam logic signed [17:0] FULL_TURN = 18'sd46080;
  localparam logic [13:0]        TAU_MAX   = 14'd10000;
  localparam logic [13:0]        TAU_RESET = 14'd1000;
  // ceil(2^43 / 15625): with the shift by three this divides by 125000,
  // exact for every 32-bit numerator
  localparam logic [29:0]        INC_RECIP = 30'd562949954;

  // inputs stay within one turn of the range, so a single add or subtract suffices
  function automatic logic signed [15:0] wrap_angle(input logic signed [17:0] x);
    logic signed [17:0] y;
    if (x > HALF_TURN) begin
      y = x - FULL_TURN;
    end else if (x < -HALF_TURN) begin
      y = x + FULL_TURN;
    end else begin
      y = x;
    end
    return y[15:0];
  endfunction

  // sequencer
  logic [PC_W-1:0] pc_q, pc_d;
  ucode_word_t     uw;
  logic            jump;

  // control state
  logic               axis_q, axis_d;
  logic               valid_q, valid_d;
  logic               acc_q, acc_d;
  logic [13:0]        tau_q;
  logic signed [15:0] roll_q, roll_d;
  logic signed [15:0] pitch_q, pitch_d;
  logic               out_valid_q, out_valid_d;

  // payload registers
  logic signed [15:0] ar_q, ap_q, gr_q, gp_q;
  logic [15:0]        dt_q;
  logic               rst_flag_q;
  logic [23:0]        den_q, den_d;
  logic [16:0]        weight_q, weight_d;
  logic signed [33:0] prod_q, prod_d;
  logic               sign_q, sign_d;
  logic [31:0]        inc_num_q, inc_num_d;
  logic signed [15:0] pred_q, pred_d;
  logic signed [15:0] diff_q, diff_d;
  logic signed [15:0] out_roll_q, out_roll_d;
  logic signed [15:0] out_pitch_q, out_pitch_d;
  logic               out_acc_q, out_acc_d;

  // datapath helpers
  logic [13:0]        tau_c;
  logic signed [15:0] est_sel, accel_sel, rate_sel;
  logic [33:0]        prod_mag;
  logic [58:0]        inc_prod;
  logic signed [17:0] inc_s;
  logic [14:0]        corr_r;
  logic signed [17:0] corr_s;
  logic signed [15:0] new_est;
  logic               out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  rpcf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign uw       = ucode_rom(pc_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (uw.cond)
      C_NEXT:        jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_NO_INPUT:    jump = !in_valid_i;
      C_RESTART:     jump = rst_flag_q;
      C_NOT_VALID:   jump = !valid_q;
      C_DT_ZERO:     jump = (dt_q == '0);
      C_DIV_BUSY:    jump = div_rsp.busy;
      C_AXIS0:       jump = !axis_q;
      C_OUT_BLOCKED: jump = !out_free;
      default:       jump = 1'b1;
    endcase
    pc_d = jump ? uw.target : pc_q + 1'b1;
  end

  assign tau_c = (tau_q == '0) ? 14'd1 : ((tau_q > TAU_MAX) ? TAU_MAX : tau_q);

  assign est_sel   = axis_q ? pitch_q : roll_q;
  assign accel_sel = axis_q ? ap_q : ar_q;
  assign rate_sel  = axis_q ? gp_q : gr_q;

  assign prod_mag = prod_q[33] ? 34'(-prod_q) : 34'(prod_q);
  // gyro increment magnitude: drop the factor of eight, then reciprocal multiply
  assign inc_prod = 59'(inc_num_q[31:3]) * 59'(INC_RECIP);
  assign inc_s    = sign_q ? -$signed({2'b00, inc_prod[58:43]})
                           : $signed({2'b00, inc_prod[58:43]});
  // round to nearest, ties away from zero, on the magnitude
  assign corr_r   = 15'((prod_mag + 34'd32768) >> 16);
  assign corr_s   = prod_q[33] ? -$signed({3'b000, corr_r}) : $signed({3'b000, corr_r});
  assign new_est  = wrap_angle(18'(pred_q) + corr_s);

  always_comb begin
    axis_d      = axis_q;
    valid_d     = valid_q;
    acc_d       = acc_q;
    roll_d      = roll_q;
    pitch_d     = pitch_q;
    den_d       = den_q;
    weight_d    = weight_q;
    prod_d      = prod_q;
    sign_d      = sign_q;
    inc_num_d   = inc_num_q;
    pred_d      = pred_q;
    diff_d      = diff_q;
    out_roll_d  = out_roll_q;
    out_pitch_d = out_pitch_q;
    out_acc_d   = out_acc_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_req     = '{start: 1'b0, num: '0, den: '0};

    case (uw.op)
      OP_DEN: begin
        den_d  = 24'(tau_c) * 24'd1000 + 24'(dt_q);
        axis_d = 1'b0;
      end
      OP_DIV_WEIGHT: begin
        // weight = (2*dt*65536 + den) / (2*den)
        div_req.start = 1'b1;
        div_req.num   = 34'({dt_q, 17'b0}) + 34'(den_q);
        div_req.den   = {den_q, 1'b0};
      end
      OP_TAKE_WEIGHT: begin
        if (!div_rsp.busy) begin
          weight_d = div_rsp.quot;
        end
      end
      OP_RATE_MUL: begin
        prod_d = 34'($signed(rate_sel) * $signed({1'b0, dt_q}));
      end
      OP_INC_ROUND: begin
        // half the divisor added for rounding, fits 32 bits
        inc_num_d = 32'(prod_mag + 34'd62500);
        sign_d    = prod_q[33];
      end
      OP_INC_SCALE: begin
        pred_d = wrap_angle(18'(est_sel) + inc_s);
      end
      OP_DIFF: begin
        diff_d = wrap_angle(18'(accel_sel) - 18'(pred_q));
      end
      OP_CORR_MUL: begin
        prod_d = 34'($signed({1'b0, weight_q}) * $signed(diff_q));
      end
      OP_CORR: begin
        if (axis_q) begin
          pitch_d = new_est;
        end else begin
          roll_d = new_est;
        end
      end
      OP_AXIS_NEXT: begin
        axis_d = ~axis_q;
      end
      OP_MARK_OK: begin
        acc_d = 1'b1;
      end
      OP_FIRST: begin
        roll_d  = wrap_angle(18'(ar_q));
        pitch_d = wrap_angle(18'(ap_q));
        valid_d = 1'b1;
        acc_d   = 1'b1;
      end
      OP_RESTART: begin
        roll_d  = '0;
        pitch_d = '0;
        valid_d = 1'b0;
        acc_d   = 1'b0;
      end
      OP_HOLD: begin
        acc_d = 1'b0;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_roll_d  = roll_q;
          out_pitch_d = pitch_q;
          out_acc_d   = acc_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_IDLE;
      axis_q      <= 1'b0;
      valid_q     <= 1'b0;
      acc_q       <= 1'b0;
      roll_q      <= '0;
      pitch_q     <= '0;
      out_valid_q <= 1'b0;
      tau_q       <= TAU_RESET;
    end else begin
      pc_q        <= pc_d;
      axis_q      <= axis_d;
      valid_q     <= valid_d;
      acc_q       <= acc_d;
      roll_q      <= roll_d;
      pitch_q     <= pitch_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        tau_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // capture the transaction while waiting in the idle step
    if (uw.op == OP_LATCH && in_valid_i) begin
      ar_q       <= accel_roll_i;
      ap_q       <= accel_pitch_i;
      gr_q       <= gyro_roll_rate_i;
      gp_q       <= gyro_pitch_rate_i;
      dt_q       <= step_time_us_i;
      rst_flag_q <= restart_i;
    end
    den_q       <= den_d;
    weight_q    <= weight_d;
    prod_q      <= prod_d;
    sign_q      <= sign_d;
    inc_num_q   <= inc_num_d;
    pred_q      <= pred_d;
    diff_q      <= diff_d;
    out_roll_q  <= out_roll_d;
    out_pitch_q <= out_pitch_d;
    out_acc_q   <= out_acc_d;
  end

  assign in_stall_o       = (pc_q != PC_IDLE);
  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign roll_estimate_o  = out_roll_q;
  assign pitch_estimate_o = out_pitch_q;
  assign accepted_o       = out_acc_q;

endmodule

`default_nettype wire

/* hw/rtl/rpcf_checker.sv */
// port-level checks for the roll and pitch complementary filter
// bound to roll_pitch_complementary_filter, sees its ports only
`timescale 1ns / 1ps
`default_nettype none

module rpcf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] roll_estimate_o,
  input logic signed [15:0] pitch_estimate_o,
  input logic               accepted_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn under stall");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(roll_estimate_o) && $stable(pitch_estimate_o)
      && $stable(accepted_o))
    else $error("result payload changed under stall");

  // estimates offered on the output lie within a half turn
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (roll_estimate_o >= -16'sd23040) && (roll_estimate_o <= 16'sd23040)
      && (pitch_estimate_o >= -16'sd23040) && (pitch_estimate_o <= 16'sd23040))
    else $error("estimate outside half turn");

  // one item in work at a time: a transaction closes the input side next cycle
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

endmodule

bind roll_pitch_complementary_filter rpcf_checker u_rpcf_checker (.*);

`default_nettype wire
